/* rtl/pcp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types and constants for the capture-file block structure checker.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int WORD_W          = 32;
  localparam int POS_W           = 23;
  localparam int LEN_W           = 25;
  localparam int OUT_W           = 48;
  localparam int COUNT_WIDTH_DEF = 48;

  localparam logic [WORD_W-1:0] SHB_TYPE  = 32'h0a0d0d0a;
  localparam logic [WORD_W-1:0] BOM_MAGIC = 32'h1a2b3c4d;
  localparam logic [WORD_W-1:0] TYPE_IDB  = 32'd1;
  localparam logic [WORD_W-1:0] TYPE_EPB  = 32'd6;

  localparam logic [WORD_W-1:0] MIN_BLOCK = 32'd12;
  localparam logic [WORD_W-1:0] MIN_SHB   = 32'd28;
  localparam logic [WORD_W-1:0] MIN_IDB   = 32'd20;
  localparam logic [WORD_W-1:0] MIN_EPB   = 32'd32;

  localparam logic [LEN_W-1:0] MAX_BLOCK_RST = LEN_W'(1024 * 1024);

  // word positions inside a block that carry checked fields
  localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY0   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CAPLEN  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_ORIGLEN = POS_W'(6);

  typedef enum logic [1:0] {
    KIND_SHB   = 2'd0,
    KIND_IDB   = 2'd1,
    KIND_EPB   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              sof;
  } pcp_item_t;

endpackage
`default_nettype wire

/* rtl/pcp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcp_core
// Parse state registers and the per-word block structure checks.
// ----------------------------------------------------------------------------
module pcp_core #(
  parameter int COUNT_WIDTH = pcp_pkg::COUNT_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               take,
  input  pcp_pkg::pcp_item_t                item,
  input  wire  [pcp_pkg::LEN_W-1:0]         max_bytes,
  output logic [COUNT_WIDTH-1:0]            count_nxt,
  output logic                              halt_nxt,
  output logic [COUNT_WIDTH-1:0]            count_q,
  output logic                              halt_q
);

  localparam int PW = pcp_pkg::POS_W;
  localparam int LW = pcp_pkg::LEN_W;
  localparam int WW = pcp_pkg::WORD_W;

  logic [PW-1:0]          pos_r, pos_nxt, pos_c, end_pos;
  pcp_pkg::kind_t         kind_r, kind_nxt, kind_c;
  logic [LW-1:0]          len_r, len_nxt, len_c;
  logic [WW-1:0]          cap_r, cap_nxt, cap_c;
  logic                   sec_r, sec_nxt, sec_c;
  logic                   ifc_r, ifc_nxt, ifc_c;
  logic                   halt_r, halt_c;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_c;
  logic [COUNT_WIDTH:0]   sum;
  logic                   fail;
  logic [WW-1:0]          w;

  assign w = item.word;

  always_comb begin
    // a new file clears everything before the word is used
    pos_c  = item.sof ? '0 : pos_r;
    kind_c = item.sof ? pcp_pkg::KIND_SHB : kind_r;
    len_c  = item.sof ? '0 : len_r;
    cap_c  = item.sof ? '0 : cap_r;
    sec_c  = item.sof ? 1'b0 : sec_r;
    ifc_c  = item.sof ? 1'b0 : ifc_r;
    halt_c = item.sof ? 1'b0 : halt_r;
    cnt_c  = item.sof ? '0 : cnt_r;

    end_pos = len_c[LW-1:2] - PW'(1);
    sum     = {1'b0, cnt_c} + (COUNT_WIDTH+1)'(len_c);

    pos_nxt   = pos_c;
    kind_nxt  = kind_c;
    len_nxt   = len_c;
    cap_nxt   = cap_c;
    sec_nxt   = sec_c;
    ifc_nxt   = ifc_c;
    count_nxt = cnt_c;
    fail      = 1'b0;

    if (!halt_c) begin
      if (pos_c == pcp_pkg::POS_TYPE) begin
        if (!sec_c) begin
          fail     = (w != pcp_pkg::SHB_TYPE);
          kind_nxt = pcp_pkg::KIND_SHB;
        end else if (w == pcp_pkg::TYPE_IDB) begin
          kind_nxt = pcp_pkg::KIND_IDB;
        end else if (w == pcp_pkg::TYPE_EPB) begin
          kind_nxt = pcp_pkg::KIND_EPB;
        end else begin
          kind_nxt = pcp_pkg::KIND_OTHER;
        end
        pos_nxt = pcp_pkg::POS_LENGTH;
      end else if (pos_c == pcp_pkg::POS_LENGTH) begin
        fail = (w < pcp_pkg::MIN_BLOCK) || (w[1:0] != 2'b00) ||
               (w > WW'(max_bytes));
        case (kind_c)
          pcp_pkg::KIND_SHB: if (w < pcp_pkg::MIN_SHB) fail = 1'b1;
          pcp_pkg::KIND_IDB: if (w < pcp_pkg::MIN_IDB) fail = 1'b1;
          pcp_pkg::KIND_EPB: if (w < pcp_pkg::MIN_EPB || !ifc_c) fail = 1'b1;
          default: ;
        endcase
        len_nxt = w[LW-1:0];
        pos_nxt = pcp_pkg::POS_BODY0;
      end else if (pos_c == end_pos) begin
        // trailing length closes the block
        if (w != WW'(len_c)) begin
          fail = 1'b1;
        end else begin
          count_nxt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
          if (kind_c == pcp_pkg::KIND_SHB) sec_nxt = 1'b1;
          if (kind_c == pcp_pkg::KIND_IDB) ifc_nxt = 1'b1;
          pos_nxt = pcp_pkg::POS_TYPE;
        end
      end else begin
        if (kind_c == pcp_pkg::KIND_SHB && pos_c == pcp_pkg::POS_BODY0 &&
            w != pcp_pkg::BOM_MAGIC) begin
          fail = 1'b1;
        end
        if (kind_c == pcp_pkg::KIND_EPB) begin
          if (pos_c == pcp_pkg::POS_BODY0 && w != '0) fail = 1'b1;
          if (pos_c == pcp_pkg::POS_CAPLEN) begin
            cap_nxt = w;
            if (w > WW'(len_c) - pcp_pkg::MIN_EPB) fail = 1'b1;
          end
          if (pos_c == pcp_pkg::POS_ORIGLEN && cap_c > w) fail = 1'b1;
        end
        pos_nxt = pos_c + PW'(1);
      end
    end

    halt_nxt = halt_c || fail;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kind_r <= pcp_pkg::KIND_SHB;
      len_r  <= '0;
      cap_r  <= '0;
      sec_r  <= 1'b0;
      ifc_r  <= 1'b0;
      halt_r <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      len_r  <= len_nxt;
      cap_r  <= cap_nxt;
      sec_r  <= sec_nxt;
      ifc_r  <= ifc_nxt;
      halt_r <= halt_nxt;
      cnt_r  <= count_nxt;
    end
  end

  assign count_q = cnt_r;
  assign halt_q  = halt_r;

endmodule
`default_nettype wire

/* rtl/pcapng_prefix_checker_unit.sv */
`default_nettype none
// A request accepted into the input register is checked there, and its result
// is loaded into the result register, where it is held until out_ready takes it.
// Throughput: one word per cycle while out_ready keeps the output draining; the
// parse state is updated from the input register with the result register load.
// Reset: synchronous active-low rst_n clears all parse state and both stages
// and sets the maximum block length to 1048576.
// ----------------------------------------------------------------------------
// pcapng_prefix_checker_unit
// Streaming block structure check of a little-endian capture file.
// ----------------------------------------------------------------------------
module pcapng_prefix_checker_unit #(
  parameter int COUNT_WIDTH = pcp_pkg::COUNT_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [pcp_pkg::WORD_W-1:0]   in_word,
  input  wire                          in_start_of_file,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [pcp_pkg::OUT_W-1:0]    out_valid_prefix_bytes,
  output logic                         out_stopped,
  input  wire                          cfg_wr_en,
  input  wire  [pcp_pkg::LEN_W-1:0]    cfg_wr_data
);

  logic [pcp_pkg::LEN_W-1:0] max_r;
  logic                      s1_valid_r;
  pcp_pkg::pcp_item_t        s1_item_r;
  logic                      out_valid_r;
  logic [pcp_pkg::OUT_W-1:0] out_count_r;
  logic                      out_stop_r;
  logic                      adv, take;
  logic [COUNT_WIDTH-1:0]    count_nxt, count_q;
  logic                      halt_nxt, halt_q;
  logic [pcp_pkg::OUT_W-1:0] count_out;

  assign adv      = !out_valid_r || out_ready;
  assign take     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= pcp_pkg::MAX_BLOCK_RST;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.word <= in_word;
      s1_item_r.sof  <= in_start_of_file;
    end
  end

  pcp_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (s1_item_r),
    .max_bytes (max_r),
    .count_nxt (count_nxt),
    .halt_nxt  (halt_nxt),
    .count_q   (count_q),
    .halt_q    (halt_q)
  );

  // result is the count, cut to its low OUT_W bits or zero-extended to OUT_W
  generate
    if (COUNT_WIDTH >= pcp_pkg::OUT_W) begin : g_trunc
      assign count_out = count_nxt[pcp_pkg::OUT_W-1:0];
    end else begin : g_ext
      assign count_out = pcp_pkg::OUT_W'(count_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_count_r <= count_out;
      out_stop_r  <= halt_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_valid_prefix_bytes = out_count_r;
  assign out_stopped            = out_stop_r;

`ifndef SYNTH
  a_halt_clears_on_sof: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(halt_q) && $past(rst_n) |-> $past(take && s1_item_r.sof))
    else $error("halt cleared without start of file");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_q < $past(count_q)) |-> $past(take && s1_item_r.sof))
    else $error("valid byte count dropped without start of file");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled while a stage is free");
`endif

endmodule
`default_nettype wire
